/* src/b62d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package b62d_pkg;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_FIN,
		S_SINGLE,
		S_SKIP,
		S_ZEROS,
		S_VAL,
		S_CLEAR
	} state_t;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK    = 3'd0;
	localparam status_t ST_EMPTY = 3'd1;
	localparam status_t ST_BAD   = 3'd2;
	localparam status_t ST_SMALL = 3'd3;
	localparam status_t ST_OVER  = 3'd4;

	localparam logic [4:0] CAP_RESET = 5'd16;
	localparam logic [4:0] REQ_SAT   = 5'd31;

	// alphabet 0-9, a-z, A-Z; bit 6 flags a character inside the alphabet
	function automatic logic [6:0] digit_of(input logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 6'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			r = {1'b1, 6'(c - 8'h61 + 8'd10)};
		end else if (c >= 8'h41 && c <= 8'h5a) begin
			r = {1'b1, 6'(c - 8'h41 + 8'd36)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/base62_string_decoder_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// base-62 string decoder (alphabet 0-9, a-z, A-Z)
// input channel: one character per beat (char_code, has_char, last_char),
// in_valid / in_stall; a beat is taken when in_valid is high and in_stall low.
// a significant character runs a serial multiply-by-62 over the stored value,
// one byte per cycle; leading '0' characters, invalid characters and empty
// beats are taken without a multiply pass. on the last beat the block
// decides, shifts the top value byte into place, then emits lz zero bytes
// and vlen value bytes, most significant first, one per cycle while
// out_stall is low, with a turnaround step per phase and a final step to
// clear the string state. an error, empty, overflowing or too-small string
// gives a single beat with last_byte set. output channel: out_valid /
// out_stall with a registered payload; while the receiver stalls the beat
// holds, and no new input is taken until the string's last beat is loaded.
// config: cfg_valid / cfg_ready write out_capacity, always ready; write only
// while idle. reset clears the string state and sets the stored capacity to 16.
module base62_string_decoder_top
	import b62d_pkg::*;
#(
	parameter int MAX_BYTES = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic [7:0] char_code,
	input  wire logic       has_char,
	input  wire logic       last_char,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic [7:0] data_byte,
	output      logic       last_byte,
	output      logic [2:0] status,
	output      logic [4:0] required_size,
	input  wire logic       cfg_valid,
	output      logic       cfg_ready,
	input  wire logic [4:0] out_capacity
);

	localparam int CW = $clog2(MAX_BYTES + 1);
	localparam int TW = CW + 1;
	localparam int KW = (TW > 5) ? TW : 5;
	localparam logic [CW-1:0] MAX_C  = CW'(MAX_BYTES);
	localparam logic [CW-1:0] LAST_C = CW'(MAX_BYTES - 1);
	localparam logic [KW-1:0] MAX_K  = KW'(MAX_BYTES);

	state_t          state_q, state_d;
	logic [7:0]      val_q [MAX_BYTES];
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [CW-1:0]   lz_q;
	logic [CW-1:0]   vlen_q;
	logic [5:0]      carry_q;
	logic            run_q, bad_q, ovf_q, last_q;
	logic [4:0]      cap_q;

	logic            out_valid_q, last_byte_q;
	logic [7:0]      data_byte_q;
	status_t         status_q;
	logic [4:0]      req_q;

	logic            load, shift_dn, shift_up, clr, slot;
	logic [7:0]      o_byte;
	logic            o_last;
	status_t         o_st;
	logic [4:0]      o_req;

	logic [6:0]      dig;
	logic            in_acc;
	logic [13:0]     prod;
	logic [KW-1:0]   total;
	logic            is_empty, is_over, is_small;

	assign dig    = digit_of(char_code);
	assign in_acc = in_valid && !in_stall;
	// v * 62 + carry, at most 61 carried into the next byte
	assign prod   = ({6'd0, val_q[0]} << 6) - ({6'd0, val_q[0]} << 1) + {8'd0, carry_q};
	assign total  = KW'(lz_q) + KW'(vlen_q);

	assign is_empty = run_q && (lz_q == '0) && !ovf_q;
	assign is_over  = ovf_q || (total > MAX_K);
	assign is_small = total > KW'(cap_q);
	assign slot     = !out_valid_q || !out_stall;

	assign in_stall      = (state_q != S_IDLE);
	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign data_byte     = data_byte_q;
	assign last_byte     = last_byte_q;
	assign status        = status_q;
	assign required_size = req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		load     = 1'b0;
		shift_dn = 1'b0;
		shift_up = 1'b0;
		clr      = 1'b0;
		o_byte   = 8'd0;
		o_last   = 1'b0;
		o_st     = ST_OK;
		o_req    = 5'd0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (has_char && dig[6] && !(run_q && dig[5:0] == 6'd0)) begin
						state_d = S_MUL;
						cnt_d   = '0;
					end else if (last_char) begin
						state_d = S_FIN;
					end
				end
			end
			S_MUL: begin
				shift_dn = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == LAST_C) begin
					state_d = last_q ? S_FIN : S_IDLE;
				end
			end
			S_FIN: begin
				if (bad_q || is_empty || is_over || is_small) begin
					state_d = S_SINGLE;
				end else begin
					state_d = S_SKIP;
					cnt_d   = MAX_C - vlen_q;
				end
			end
			S_SINGLE: begin
				o_last = 1'b1;
				if (bad_q) begin
					o_st = ST_BAD;
				end else if (is_empty) begin
					o_st = ST_EMPTY;
				end else if (is_over) begin
					o_st = ST_OVER;
				end else begin
					o_st  = ST_SMALL;
					o_req = (total > KW'(REQ_SAT)) ? REQ_SAT : total[4:0];
				end
				if (slot) begin
					load    = 1'b1;
					state_d = S_CLEAR;
				end
			end
			S_SKIP: begin
				// bring the top value byte to the high end of the register
				if (cnt_q == '0) begin
					state_d = S_ZEROS;
					cnt_d   = lz_q;
				end else begin
					shift_up = 1'b1;
					cnt_d    = cnt_q - 1'b1;
				end
			end
			S_ZEROS: begin
				o_last = (cnt_q == CW'(1)) && (vlen_q == '0);
				if (cnt_q == '0) begin
					state_d = S_VAL;
					cnt_d   = vlen_q;
				end else if (slot) begin
					load  = 1'b1;
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_VAL: begin
				o_byte = val_q[MAX_BYTES-1];
				o_last = (cnt_q == CW'(1));
				if (cnt_q == '0) begin
					state_d = S_CLEAR;
				end else if (slot) begin
					load     = 1'b1;
					shift_up = 1'b1;
					cnt_d    = cnt_q - 1'b1;
				end
			end
			S_CLEAR: begin
				clr     = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BYTES; i++) begin
				val_q[i] <= 8'd0;
			end
			cnt_q   <= '0;
			lz_q    <= '0;
			vlen_q  <= '0;
			carry_q <= 6'd0;
			run_q   <= 1'b1;
			bad_q   <= 1'b0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (in_acc) begin
				last_q <= last_char;
				if (has_char) begin
					if (!dig[6]) begin
						bad_q <= 1'b1;
						run_q <= 1'b0;
					end else if (run_q && dig[5:0] == 6'd0) begin
						if (lz_q < MAX_C) begin
							lz_q <= lz_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end else begin
						run_q   <= 1'b0;
						carry_q <= dig[5:0];
					end
				end
			end
			if (shift_dn) begin
				for (int i = 0; i < MAX_BYTES - 1; i++) begin
					val_q[i] <= val_q[i+1];
				end
				val_q[MAX_BYTES-1] <= prod[7:0];
				carry_q <= prod[13:8];
				// highest nonzero byte is rebuilt on every pass
				if (cnt_q == '0) begin
					vlen_q <= (prod[7:0] != 8'd0) ? CW'(1) : '0;
				end else if (prod[7:0] != 8'd0) begin
					vlen_q <= cnt_q + 1'b1;
				end
				if (cnt_q == LAST_C && prod[13:8] != 6'd0) begin
					ovf_q <= 1'b1;
				end
			end
			if (shift_up) begin
				for (int i = MAX_BYTES - 1; i > 0; i--) begin
					val_q[i] <= val_q[i-1];
				end
				val_q[0] <= 8'd0;
			end
			if (clr) begin
				for (int i = 0; i < MAX_BYTES; i++) begin
					val_q[i] <= 8'd0;
				end
				lz_q   <= '0;
				vlen_q <= '0;
				run_q  <= 1'b1;
				bad_q  <= 1'b0;
				ovf_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= out_capacity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_byte_q <= o_byte;
			last_byte_q <= o_last;
			status_q    <= o_st;
			req_q       <= o_req;
		end
	end

endmodule

`default_nettype wire
